// ===== hw/rtl/hsl_pkg.sv =====
package hsl_pkg;

    localparam int CHAN_BITS   = 16;
    localparam int FRAC_BITS   = 8;
    localparam int FACTOR_BITS = FRAC_BITS + 2;
    localparam int HUE_BITS    = CHAN_BITS + 3;
    localparam int DIV_LAT     = CHAN_BITS + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int WORD_BITS   = ((4 * CHAN_BITS + 7) / 8) * 8;

    localparam logic [CHAN_BITS-1:0]   FULL         = {CHAN_BITS{1'b1}};
    localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = FACTOR_BITS'(1) << FRAC_BITS;

    typedef logic [CHAN_BITS-1:0] chan_t;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } hue_sect_t;

    typedef struct packed {
        chan_t     lum;
        chan_t     sat_num;
        chan_t     sat_den;
        chan_t     hue_num;
        chan_t     hue_den;
        logic      hue_neg;
        hue_sect_t sect;
        logic      gray;
        chan_t     alpha;
    } hsl_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } hsl_q_stat_t;

endpackage

// ===== hw/rtl/hsl_front.sv =====
module hsl_front
    import hsl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [WORD_BITS-1:0] s_tdata,   // red, green, blue, alpha
    input  logic                 push_ok,
    output logic                 item_valid,
    output hsl_item_t            item
);

    logic      vld_reg, vld_next;
    hsl_item_t item_reg, item_next;

    chan_t r, g, b;
    chan_t mx, mn;
    logic  r_max, g_max;
    logic [CHAN_BITS:0] sum, dsig;

    assign r = s_tdata[CHAN_BITS-1:0];
    assign g = s_tdata[2*CHAN_BITS-1:CHAN_BITS];
    assign b = s_tdata[3*CHAN_BITS-1:2*CHAN_BITS];

    assign s_tready   = !vld_reg || push_ok;
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_comb begin
        r_max = (r >= g) && (r >= b);
        g_max = !r_max && (g >= b);
        mx = r_max ? r : (g_max ? g : b);
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        sum = {1'b0, mx} + {1'b0, mn};

        item_next.lum     = sum[CHAN_BITS:1];
        item_next.sat_num = mx - mn;
        item_next.hue_den = mx - mn;
        item_next.gray    = (mx == mn);
        item_next.alpha   = s_tdata[4*CHAN_BITS-1:3*CHAN_BITS];
        if (sum <= {1'b0, FULL}) begin
            item_next.sat_den = sum[CHAN_BITS-1:0];
        end else begin
            item_next.sat_den = CHAN_BITS'({FULL, 1'b0} - sum);
        end

        if (r_max) begin
            item_next.sect = SECT_RED;
            dsig = {1'b0, g} - {1'b0, b};
        end else if (g_max) begin
            item_next.sect = SECT_GREEN;
            dsig = {1'b0, b} - {1'b0, r};
        end else begin
            item_next.sect = SECT_BLUE;
            dsig = {1'b0, r} - {1'b0, g};
        end
        item_next.hue_neg = dsig[CHAN_BITS];
        item_next.hue_num = dsig[CHAN_BITS] ? CHAN_BITS'(-dsig) : dsig[CHAN_BITS-1:0];

        if (s_tvalid && s_tready) begin
            vld_next = 1'b1;
        end else if (push_ok) begin
            vld_next = 1'b0;
        end else begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== hw/rtl/hsl_queue.sv =====
module hsl_queue
    import hsl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  hsl_item_t   din,
    input  logic        pop,
    output hsl_item_t   dout,
    output hsl_q_stat_t stat
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    hsl_item_t mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [PTR_BITS:0]   cnt_reg, cnt_next;
    logic do_push, do_pop;

    assign stat.full  = (cnt_reg == (PTR_BITS + 1)'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign dout       = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (PTR_BITS + 1)'(do_push) - (PTR_BITS + 1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== hw/rtl/hsl_div.sv =====
module hsl_div
    import hsl_pkg::*;
(
    input  logic  aclk,
    input  logic  en,
    input  chan_t num,
    input  chan_t den,
    output chan_t quo
);

    localparam int W = CHAN_BITS;

    chan_t rem_reg [W];
    chan_t low_reg [W];
    chan_t den_reg [W];
    chan_t quo_reg [W];
    chan_t quo_out_reg;
    logic [2*W-1:0] dvd;

    assign dvd = {num, {W{1'b0}}} - {{W{1'b0}}, num};
    assign quo = quo_out_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= dvd[2*W-1:W];
            low_reg[0] <= dvd[W-1:0];
            den_reg[0] <= den;
            quo_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < W; k++) begin : g_step
        logic [W:0] trial;
        logic       ge;
        chan_t      rem_next, quo_next;

        always_comb begin
            trial    = {rem_reg[k], low_reg[k][W-1]};
            ge       = trial >= {1'b0, den_reg[k]};
            rem_next = ge ? W'(trial - {1'b0, den_reg[k]}) : trial[W-1:0];
            quo_next = {quo_reg[k][W-2:0], ge};
        end

        if (k < W - 1) begin : g_mid
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1] <= rem_next;
                    low_reg[k+1] <= {low_reg[k][W-2:0], 1'b0};
                    den_reg[k+1] <= den_reg[k];
                    quo_reg[k+1] <= quo_next;
                end
            end
        end else begin : g_last
            always_ff @(posedge aclk) begin
                if (en) begin
                    quo_out_reg <= quo_next;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/hsl_back.sv =====
module hsl_back
    import hsl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   item_valid,
    input  hsl_item_t              item,
    output logic                   pop,
    input  logic [FACTOR_BITS-1:0] shade_factor,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [WORD_BITS-1:0]   m_tdata   // red, green, blue, alpha
);

    localparam int N = CHAN_BITS;
    localparam logic [HUE_BITS-1:0] F1 = HUE_BITS'(FULL);
    localparam logic [HUE_BITS-1:0] F2 = HUE_BITS'(2 * int'(FULL));
    localparam logic [HUE_BITS-1:0] F3 = HUE_BITS'(3 * int'(FULL));
    localparam logic [HUE_BITS-1:0] F4 = HUE_BITS'(4 * int'(FULL));
    localparam logic [HUE_BITS-1:0] F6 = HUE_BITS'(6 * int'(FULL));

    function automatic chan_t div_full(input logic [2*N-1:0] x);
        chan_t      q0;
        logic [N:0] r;
        q0 = x[2*N-1:N];
        r  = {1'b0, x[N-1:0]} + {1'b0, q0};
        return (r >= {1'b0, FULL}) ? q0 + 1'b1 : q0;
    endfunction

    function automatic chan_t ramp(input logic [HUE_BITS-1:0] t);
        chan_t m;
        if (t < F1) begin
            m = t[N-1:0];
        end else if (t < F3) begin
            m = FULL;
        end else if (t < F4) begin
            m = N'(F4 - t);
        end else begin
            m = '0;
        end
        return m;
    endfunction

    function automatic chan_t shade(input chan_t v, input logic [FACTOR_BITS-1:0] f);
        logic [N+FACTOR_BITS-1:0] p;
        p = {{FACTOR_BITS{1'b0}}, v} * {{N{1'b0}}, f};
        return (p[N+FACTOR_BITS-1:FRAC_BITS] > (N + 2)'(FULL)) ? FULL
                                                           : p[N+FRAC_BITS-1:FRAC_BITS];
    endfunction

    logic adv;
    chan_t sat_q, hue_q;

    // payload riding alongside the dividers
    logic      dly_vld_reg   [DIV_LAT];
    chan_t     dly_lum_reg   [DIV_LAT];
    chan_t     dly_alpha_reg [DIV_LAT];
    logic      dly_neg_reg   [DIV_LAT];
    hue_sect_t dly_sect_reg  [DIV_LAT];
    logic      dly_gray_reg  [DIV_LAT];

    logic                vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg, out_vld_reg;
    logic [HUE_BITS-1:0] hue1_reg, hue2_reg;
    chan_t               ls1_reg, ss1_reg, ls2_reg, ss2_reg, a1_reg, a2_reg;
    logic [2*N-1:0]      prod2_reg;
    chan_t               lo3_reg, dif3_reg, ls3_reg, a3_reg;
    logic                gray3_reg, gray4_reg, gray5_reg;
    logic [HUE_BITS-1:0] t3_reg [3];
    chan_t               m4_reg [3];
    chan_t               lo4_reg, dif4_reg, ls4_reg, a4_reg;
    logic [2*N-1:0]      pc5_reg [3];
    chan_t               lo5_reg, ls5_reg, a5_reg;
    logic [WORD_BITS-1:0] out_reg;

    logic [HUE_BITS-1:0] hue1_next;
    logic [HUE_BITS:0]   hsum;
    chan_t               p3;
    logic [N+1:0]        hi3, lo3;
    logic [HUE_BITS-1:0] t3_next [3];
    logic [WORD_BITS-1:0] out_next;

    assign adv      = !out_vld_reg || m_tready;
    assign pop      = adv && item_valid;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    hsl_div u_sat_div (
        .aclk (aclk),
        .en   (adv),
        .num  (item.sat_num),
        .den  (item.sat_den),
        .quo  (sat_q)
    );

    hsl_div u_hue_div (
        .aclk (aclk),
        .en   (adv),
        .num  (item.hue_num),
        .den  (item.hue_den),
        .quo  (hue_q)
    );

    always_comb begin
        unique case (dly_sect_reg[DIV_LAT-1])
            SECT_GREEN: hsum = {1'b0, F2};
            SECT_BLUE:  hsum = {1'b0, F4};
            default:    hsum = '0;
        endcase
        if (dly_neg_reg[DIV_LAT-1]) begin
            hsum = hsum - (HUE_BITS + 1)'(hue_q);
        end else begin
            hsum = hsum + (HUE_BITS + 1)'(hue_q);
        end
        hue1_next = hsum[HUE_BITS] ? HUE_BITS'(hsum + {1'b0, F6}) : hsum[HUE_BITS-1:0];

        p3 = div_full(prod2_reg);
        if ({1'b0, ls2_reg, 1'b0} <= (N + 2)'(FULL)) begin
            hi3 = (N + 2)'(ls2_reg) + (N + 2)'(p3);
        end else begin
            hi3 = (N + 2)'(ls2_reg) + (N + 2)'(ss2_reg) - (N + 2)'(p3);
        end
        lo3 = {1'b0, ls2_reg, 1'b0} - hi3;

        t3_next[0] = hue2_reg + F2;
        if (t3_next[0] > F6) t3_next[0] = t3_next[0] - F6;
        t3_next[1] = hue2_reg;
        t3_next[2] = (hue2_reg >= F2) ? hue2_reg - F2 : hue2_reg + F4;

        out_next = '0;
        for (int c = 0; c < 3; c++) begin
            logic [N:0] v;
            v = {1'b0, lo5_reg} + {1'b0, div_full(pc5_reg[c])};
            out_next[c*N +: N] = gray5_reg ? ls5_reg : (v[N] ? FULL : v[N-1:0]);
        end
        out_next[3*N +: N] = a5_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DIV_LAT; k++) dly_vld_reg[k] <= 1'b0;
            vld1_reg    <= 1'b0;
            vld2_reg    <= 1'b0;
            vld3_reg    <= 1'b0;
            vld4_reg    <= 1'b0;
            vld5_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            dly_vld_reg[0] <= item_valid;
            for (int k = 1; k < DIV_LAT; k++) dly_vld_reg[k] <= dly_vld_reg[k-1];
            vld1_reg    <= dly_vld_reg[DIV_LAT-1];
            vld2_reg    <= vld1_reg;
            vld3_reg    <= vld2_reg;
            vld4_reg    <= vld3_reg;
            vld5_reg    <= vld4_reg;
            out_vld_reg <= vld5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dly_lum_reg[0]   <= item.lum;
            dly_alpha_reg[0] <= item.alpha;
            dly_neg_reg[0]   <= item.hue_neg;
            dly_sect_reg[0]  <= item.sect;
            dly_gray_reg[0]  <= item.gray;
            for (int k = 1; k < DIV_LAT; k++) begin
                dly_lum_reg[k]   <= dly_lum_reg[k-1];
                dly_alpha_reg[k] <= dly_alpha_reg[k-1];
                dly_neg_reg[k]   <= dly_neg_reg[k-1];
                dly_sect_reg[k]  <= dly_sect_reg[k-1];
                dly_gray_reg[k]  <= dly_gray_reg[k-1];
            end

            hue1_reg <= hue1_next;
            ls1_reg  <= shade(dly_lum_reg[DIV_LAT-1], shade_factor);
            ss1_reg  <= shade(dly_gray_reg[DIV_LAT-1] ? '0 : sat_q, shade_factor);
            a1_reg   <= dly_alpha_reg[DIV_LAT-1];

            prod2_reg <= {{N{1'b0}}, ls1_reg} * {{N{1'b0}}, ss1_reg};
            hue2_reg  <= hue1_reg;
            ls2_reg   <= ls1_reg;
            ss2_reg   <= ss1_reg;
            a2_reg    <= a1_reg;

            lo3_reg   <= lo3[N-1:0];
            dif3_reg  <= N'(hi3 - lo3);
            ls3_reg   <= ls2_reg;
            gray3_reg <= (ss2_reg == '0);
            a3_reg    <= a2_reg;
            for (int c = 0; c < 3; c++) t3_reg[c] <= t3_next[c];

            for (int c = 0; c < 3; c++) m4_reg[c] <= ramp(t3_reg[c]);
            lo4_reg   <= lo3_reg;
            dif4_reg  <= dif3_reg;
            ls4_reg   <= ls3_reg;
            gray4_reg <= gray3_reg;
            a4_reg    <= a3_reg;

            for (int c = 0; c < 3; c++) begin
                pc5_reg[c] <= {{N{1'b0}}, dif4_reg} * {{N{1'b0}}, m4_reg[c]};
            end
            lo5_reg   <= lo4_reg;
            ls5_reg   <= ls4_reg;
            gray5_reg <= gray4_reg;
            a5_reg    <= a4_reg;

            out_reg <= out_next;
        end
    end

endmodule

// ===== hw/rtl/hsl_color_shader.sv =====
// Path from an accepted input word to its output word: 1 front register, 1 queue,
// 17 divider stages, 5 shading stages, 1 output register. Throughput: one word per
// cycle unless m_tready stalls; the pipelined saturation and hue dividers set the depth.
// Reset (aresetn low, synchronous) empties the pipeline and queue and sets the
// shade factor to 1.0.
module hsl_color_shader
    import hsl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [FACTOR_BITS-1:0] cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [WORD_BITS-1:0]   s_tdata,   // red_in, green_in, blue_in, alpha_in
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [WORD_BITS-1:0]   m_tdata    // red_out, green_out, blue_out, alpha_out
);

    logic [FACTOR_BITS-1:0] shade_factor_reg;
    logic        front_valid, pop;
    hsl_item_t   front_item, q_item;
    hsl_q_stat_t q_stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shade_factor_reg <= FACTOR_RESET;
        end else if (cfg_wr_en) begin
            shade_factor_reg <= cfg_wr_data;
        end
    end

    hsl_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_ok    (!q_stat.full),
        .item_valid (front_valid),
        .item       (front_item)
    );

    hsl_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (front_valid),
        .din     (front_item),
        .pop     (pop),
        .dout    (q_item),
        .stat    (q_stat)
    );

    hsl_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (!q_stat.empty),
        .item         (q_item),
        .pop          (pop),
        .shade_factor (shade_factor_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

`ifndef SYNTHESIS
    a_q_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (front_valid && q_stat.full))
        else $error("front stalled without full queue");

    a_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && q_stat.full) |=> !q_stat.full || (front_valid && $past(front_valid)))
        else $error("queue drain lost");
`endif

endmodule
